@@ sv/bmp2rgb_pkg.sv @@
// Shared types and constants of the BMP to RGB565 streamer.
package bmp2rgb_pkg;

    // Header layout (byte positions in the file)
    localparam logic [31:0] OFFSET_BASE  = 32'd10;
    localparam logic [31:0] WIDTH_BASE   = 32'd18;
    localparam logic [31:0] HEIGHT_BASE  = 32'd22;
    localparam logic [31:0] PLANES_BASE  = 32'd26;
    localparam logic [31:0] COMP_BASE    = 32'd30;
    localparam logic [31:0] HDR_LAST_POS = 32'd33;
    localparam logic [31:0] MIN_OFFSET   = 32'd34;

    // planes = 1 in bits 15:0, bit count = 24 in bits 31:16
    localparam logic [31:0] PLANES_DEPTH_OK = {16'd24, 16'd1};

    // Image width carried to the back end; covers the largest allowed width
    localparam int IMG_W_BITS  = 14;
    // Row stride in bytes, (3 * width + 3) & ~3
    localparam int STRIDE_BITS = 15;

    // Result kinds
    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_ACCEPT,
        OP_REJECT,
        OP_DATA
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [7:0]            data;
        logic [IMG_W_BITS-1:0] width;
        logic [31:0]           height;
    } entry_t;

endpackage

@@ sv/bmp24_to_rgb565_streamer.sv @@
// Top level of the 24-bit BMP to RGB565 pixel streamer.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-------------------------------------------
//   s_      | in  | s_valid / s_ready  | s_start_of_file, s_data_byte
//   m_      | out | m_valid / m_ready  | m_kind, m_pix_x, m_pix_y, m_color, m_image_done
//
// One file byte per cycle sustained; the front end takes a beat whenever the
// two-entry queue has room. A result reaches m_ through the queue write and
// then the back end's result register.
// Reset: aresetn synchronous, active low; clears the byte counter, header
// fields, phases, queue pointers and m_valid. No clearing pass.
// Stalls: with m_ready low and a result held, the back end holds it and stops
// reading the queue; s_ready drops once both queue entries are full.
module bmp24_to_rgb565_streamer
    import bmp2rgb_pkg::*;
#(
    parameter int PANEL_WIDTH     = 128,
    parameter int PANEL_HEIGHT    = 128,
    parameter int MAX_IMAGE_WIDTH = 1280
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_start_of_file,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [6:0]  m_pix_x,
    output logic [6:0]  m_pix_y,
    output logic [15:0] m_color,
    output logic        m_image_done
);

    // front end -> queue
    logic   push_valid;
    logic   push_ready;
    entry_t push_entry;

    // queue -> back end
    logic   pop_valid;
    logic   pop;
    entry_t pop_entry;

    // Header parse and byte classification. Only the header verdict and bytes
    // from the data offset on enter the queue; other bytes are dropped here.
    bmp2rgb_front #(
        .MAX_IMAGE_WIDTH(MAX_IMAGE_WIDTH)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_start_of_file (s_start_of_file),
        .s_data_byte     (s_data_byte),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_entry      (push_entry)
    );

    // Decouples byte intake from result stalls.
    bmp2rgb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_entry  (pop_entry)
    );

    // Row walk, crop, centering and RGB565 packing; owns the result register.
    // The accept entry carries width and height so geometry stays in order
    // with the bytes of its own file.
    bmp2rgb_back #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (pop_valid),
        .q_pop        (pop),
        .q_entry      (pop_entry),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_pix_x      (m_pix_x),
        .m_pix_y      (m_pix_y),
        .m_color      (m_color),
        .m_image_done (m_image_done)
    );

endmodule

@@ sv/bmp2rgb_front.sv @@
// Front end: byte counter, header parse and check, forwards results and pixel bytes.
module bmp2rgb_front
    import bmp2rgb_pkg::*;
#(
    parameter int MAX_IMAGE_WIDTH = 1280
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_start_of_file,
    input  logic [7:0] s_data_byte,
    output logic       push_valid,
    input  logic       push_ready,
    output entry_t     push_entry
);

    typedef enum logic [1:0] {
        F_HEADER,
        F_WAIT,
        F_DATA,
        F_IDLE
    } front_phase_t;

    front_phase_t phase_reg, phase_next, phase_cur;
    logic [31:0]  pos_reg, pos_next, pos_cur;
    logic [31:0]  offset_reg, offset_next, offset_cur;
    logic [31:0]  width_reg, width_next, width_cur;
    logic [31:0]  height_reg, height_next, height_cur;
    logic [31:0]  planes_reg, planes_next, planes_cur;
    logic [31:0]  comp_reg, comp_next, comp_cur;
    logic         beat;
    logic         hdr_ok;

    function automatic logic [31:0] put_byte(input logic [31:0] f, input logic [31:0] pos,
                                             input logic [31:0] base, input logic [7:0] b);
        logic [31:0] r;
        logic [1:0]  sel;
        r   = f;
        sel = 2'(pos - base);
        if (pos >= base && pos < base + 32'd4) begin
            r[{sel, 3'b000} +: 8] = b;
        end
        return r;
    endfunction

    assign s_ready = push_ready;
    assign beat    = s_valid && s_ready;

    // start of file restarts parsing on this very byte
    always_comb begin
        phase_cur  = s_start_of_file ? F_HEADER : phase_reg;
        pos_cur    = s_start_of_file ? 32'd0 : pos_reg;
        offset_cur = s_start_of_file ? 32'd0 : offset_reg;
        width_cur  = s_start_of_file ? 32'd0 : width_reg;
        height_cur = s_start_of_file ? 32'd0 : height_reg;
        planes_cur = s_start_of_file ? 32'd0 : planes_reg;
        comp_cur   = s_start_of_file ? 32'd0 : comp_reg;
    end

    always_comb begin
        phase_next  = phase_cur;
        pos_next    = (pos_cur == 32'hFFFF_FFFF) ? pos_cur : pos_cur + 32'd1;
        offset_next = offset_cur;
        width_next  = width_cur;
        height_next = height_cur;
        planes_next = planes_cur;
        comp_next   = comp_cur;
        hdr_ok      = 1'b0;
        push_valid  = 1'b0;
        push_entry  = '{op: OP_DATA, data: s_data_byte,
                        width: width_cur[IMG_W_BITS-1:0], height: height_cur};

        unique case (phase_cur)
            F_HEADER: begin
                offset_next = put_byte(offset_cur, pos_cur, OFFSET_BASE, s_data_byte);
                width_next  = put_byte(width_cur,  pos_cur, WIDTH_BASE,  s_data_byte);
                height_next = put_byte(height_cur, pos_cur, HEIGHT_BASE, s_data_byte);
                planes_next = put_byte(planes_cur, pos_cur, PLANES_BASE, s_data_byte);
                comp_next   = put_byte(comp_cur,   pos_cur, COMP_BASE,   s_data_byte);
                hdr_ok = (planes_next == PLANES_DEPTH_OK)
                      && (comp_next == 32'd0)
                      && (width_next != 32'd0)
                      && (width_next <= 32'(MAX_IMAGE_WIDTH))
                      && (height_next != 32'd0)
                      && (offset_next >= MIN_OFFSET);
                if (pos_cur == HDR_LAST_POS) begin
                    push_valid       = beat;
                    push_entry.op    = hdr_ok ? OP_ACCEPT : OP_REJECT;
                    push_entry.width = width_next[IMG_W_BITS-1:0];
                    push_entry.height = height_next;
                    phase_next       = hdr_ok ? F_WAIT : F_IDLE;
                end
            end
            F_WAIT: begin
                if (pos_cur == offset_cur) begin
                    push_valid = beat;
                    phase_next = F_DATA;
                end
            end
            F_DATA: begin
                push_valid = beat;
            end
            F_IDLE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= F_HEADER;
            pos_reg    <= '0;
            offset_reg <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            planes_reg <= '0;
            comp_reg   <= '0;
        end else if (beat) begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            offset_reg <= offset_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            planes_reg <= planes_next;
            comp_reg   <= comp_next;
        end
    end

endmodule

@@ sv/bmp2rgb_queue.sv @@
// Two-entry queue between the front end and the pixel back end.
module bmp2rgb_queue
    import bmp2rgb_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push_valid,
    output logic   push_ready,
    input  entry_t push_entry,
    output logic   pop_valid,
    input  logic   pop,
    output entry_t pop_entry
);

    entry_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> push_ready)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> pop_valid)
        else $error("pop from empty queue");
    a_push_pop_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && do_pop) |=> count_reg == $past(count_reg))
        else $error("count moved on push and pop");
`endif

endmodule

@@ sv/bmp2rgb_back.sv @@
// Back end: row walker, cropping, centering, RGB565 packing and result register.
module bmp2rgb_back
    import bmp2rgb_pkg::*;
#(
    parameter int PANEL_WIDTH  = 128,
    parameter int PANEL_HEIGHT = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_pop,
    input  entry_t      q_entry,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [6:0]  m_pix_x,
    output logic [6:0]  m_pix_y,
    output logic [15:0] m_color,
    output logic        m_image_done
);

    localparam int CW = $clog2(PANEL_WIDTH + 1);
    localparam int RW = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;

    typedef enum logic {
        B_IDLE,
        B_ROWS
    } back_phase_t;

    back_phase_t            phase_reg, phase_next;
    logic [31:0]            skip_reg, skip_next;
    logic [STRIDE_BITS-1:0] rbc_reg, rbc_next;
    logic [STRIDE_BITS-1:0] stride_reg, stride_next;
    logic [1:0]             sub_reg, sub_next;
    logic [CW-1:0]          col_reg, col_next;
    logic [CW-1:0]          sw_reg, sw_next;
    logic [CW-1:0]          fcol_reg, fcol_next;
    logic [RW-1:0]          row_reg, row_next;
    logic [RW-1:0]          low_reg, low_next;
    logic [10:0]            part_reg, part_next;

    logic                   valid_reg;
    logic [1:0]             kind_reg, kind_next;
    logic [6:0]             x_reg, x_next;
    logic [6:0]             y_reg, y_next;
    logic [15:0]            color_reg, color_next;
    logic                   done_reg, done_next;
    logic                   emit;
    logic                   emit_last;

    // geometry from the header
    logic [15:0]            w3;
    logic [15:0]            stride_full;
    logic                   w_big;
    logic                   h_big;
    logic [31:0]            low32;
    logic [31:0]            start32;
    logic [STRIDE_BITS-1:0] rbc_inc;
    logic                   row_end;
    logic                   in_region;
    logic [31:0]            x_full;
    logic [31:0]            y_full;

    assign q_pop = q_valid && (!valid_reg || m_ready);

    always_comb begin
        w3          = {1'b0, q_entry.width, 1'b0} + {2'b00, q_entry.width};
        stride_full = (w3 + 16'd3) & ~16'd3;
        w_big       = 32'(q_entry.width) > 32'(PANEL_WIDTH);
        h_big       = q_entry.height > 32'(PANEL_HEIGHT);
        low32       = h_big ? 32'd0 : ((32'(PANEL_HEIGHT) - q_entry.height) >> 1);
        start32     = h_big ? 32'(PANEL_HEIGHT) - 32'd1 : low32 + q_entry.height - 32'd1;
    end

    assign rbc_inc   = rbc_reg + 1'b1;
    assign row_end   = rbc_inc >= stride_reg;
    assign in_region = col_reg < sw_reg;
    assign x_full    = 32'(fcol_reg) + 32'(col_reg);
    assign y_full    = 32'(row_reg);

    always_comb begin
        phase_next  = phase_reg;
        skip_next   = skip_reg;
        rbc_next    = rbc_reg;
        stride_next = stride_reg;
        sub_next    = sub_reg;
        col_next    = col_reg;
        sw_next     = sw_reg;
        fcol_next   = fcol_reg;
        row_next    = row_reg;
        low_next    = low_reg;
        part_next   = part_reg;
        emit        = 1'b0;
        emit_last   = 1'b0;
        kind_next   = KIND_PIXEL;
        x_next      = '0;
        y_next      = '0;
        color_next  = '0;
        done_next   = 1'b0;

        if (q_pop) begin
            unique case (q_entry.op)
                OP_ACCEPT: begin
                    phase_next  = B_ROWS;
                    stride_next = stride_full[STRIDE_BITS-1:0];
                    sw_next     = w_big ? CW'(PANEL_WIDTH) : CW'(q_entry.width);
                    fcol_next   = w_big ? '0
                                : CW'((32'(PANEL_WIDTH) - 32'(q_entry.width)) >> 1);
                    skip_next   = h_big ? q_entry.height - 32'(PANEL_HEIGHT) : 32'd0;
                    row_next    = RW'(start32);
                    low_next    = RW'(low32);
                    rbc_next    = '0;
                    sub_next    = '0;
                    col_next    = '0;
                    part_next   = '0;
                    emit        = 1'b1;
                    kind_next   = KIND_ACCEPT;
                end
                OP_REJECT: begin
                    phase_next = B_IDLE;
                    emit       = 1'b1;
                    kind_next  = KIND_REJECT;
                end
                OP_DATA: begin
                    if (phase_reg == B_ROWS) begin
                        if (skip_reg != 32'd0) begin
                            // rows below the panel are passed over whole
                            if (row_end) begin
                                rbc_next  = '0;
                                skip_next = skip_reg - 32'd1;
                            end else begin
                                rbc_next = rbc_inc;
                            end
                        end else begin
                            if (in_region) begin
                                unique case (sub_reg)
                                    2'd0: begin
                                        part_next = {6'd0, q_entry.data[7:3]};
                                        sub_next  = 2'd1;
                                    end
                                    2'd1: begin
                                        part_next = {q_entry.data[7:2], part_reg[4:0]};
                                        sub_next  = 2'd2;
                                    end
                                    default: begin
                                        emit       = 1'b1;
                                        emit_last  = ((col_reg + 1'b1) == sw_reg)
                                                  && (row_reg == low_reg);
                                        kind_next  = KIND_PIXEL;
                                        x_next     = x_full[6:0];
                                        y_next     = y_full[6:0];
                                        color_next = {q_entry.data[7:3], part_reg};
                                        done_next  = emit_last;
                                        sub_next   = 2'd0;
                                        col_next   = col_reg + 1'b1;
                                    end
                                endcase
                            end
                            if (emit_last) begin
                                phase_next = B_IDLE;
                            end else if (row_end) begin
                                rbc_next = '0;
                                sub_next = 2'd0;
                                col_next = '0;
                                if (row_reg != '0) begin
                                    row_next = row_reg - 1'b1;
                                end
                            end else begin
                                rbc_next = rbc_inc;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= B_IDLE;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            if (q_pop && emit) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        skip_reg   <= skip_next;
        rbc_reg    <= rbc_next;
        stride_reg <= stride_next;
        sub_reg    <= sub_next;
        col_reg    <= col_next;
        sw_reg     <= sw_next;
        fcol_reg   <= fcol_next;
        row_reg    <= row_next;
        low_reg    <= low_next;
        part_reg   <= part_next;
        if (q_pop && emit) begin
            kind_reg  <= kind_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            color_reg <= color_next;
            done_reg  <= done_next;
        end
    end

    assign m_valid      = valid_reg;
    assign m_kind       = kind_reg;
    assign m_pix_x      = x_reg;
    assign m_pix_y      = y_reg;
    assign m_color      = color_reg;
    assign m_image_done = done_reg;

`ifndef SYNTHESIS
    a_done_is_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_image_done) |-> m_kind == KIND_PIXEL)
        else $error("image done on a header result");
    a_hdr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != KIND_PIXEL) |->
            (m_pix_x == 7'd0 && m_pix_y == 7'd0 && m_color == 16'd0))
        else $error("header result with nonzero payload");
    a_last_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && emit_last) |=> phase_reg == B_IDLE)
        else $error("back end still walking after last pixel");
`endif

endmodule
